@@ src/page_refcount_table_defines.svh @@
// Assertion macros for the page reference count table.
`ifndef PAGE_REFCOUNT_TABLE_DEFINES_SVH
`define PAGE_REFCOUNT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/prt_pkg.sv @@
// Shared types and codes for the page reference count table.
package prt_pkg;

    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;
    localparam int ADDR_W     = 48;
    localparam int LIVE_OUT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Request codes; the unused code is handled as a query.
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEREGISTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_ABSENT    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_READ,
        S_EXEC
    } t_state;

endpackage

@@ src/prt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module prt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/page_refcount_table.sv @@
// Page reference count table: per-page 16-bit counts in two-level groups.
//
// One request word per start pulse: register (count up), deregister (count
// down) or query a page, given by a physical byte address whose page number
// is phys_addr >> PAGE_BITS. Every request gives exactly one result word on
// o_status / o_ref_count / o_live_groups, shown for a single cycle with
// o_valid high; the receiver cannot stall, so the result must be taken in
// that cycle.
//
// Steps: an in-range request is accepted from idle and then keeps busy high
// through the group index multiply, memory read, and update and write back
// states. The result strobe comes in the cycle after the update, and that
// same cycle may already accept the next request, so the block takes no new
// request until the last one has been written back. A page number beyond
// the table goes from the multiply step straight back to idle. The sequence
// follows from the registered read of the count and group memories and the
// registered reciprocal multiply that turns a page number into a group index.
//
// After reset the block sweeps both memories to zero, one entry a cycle,
// over all ENTRIES_PER_GROUP * NUM_GROUPS page entries (65536 at the
// defaults); busy stays high for the whole sweep.
//
// Groups: a group goes live on its first registration and is released once
// its count of nonzero entries falls to zero. Since a released group holds
// only zero counts, it restarts from zero when it becomes live again.
// Overflow and underflow are reported and leave all state untouched.
`include "page_refcount_table_defines.svh"

module page_refcount_table #(
    parameter int PAGE_BITS         = 12,
    parameter int ENTRIES_PER_GROUP = 1024,
    parameter int NUM_GROUPS        = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [prt_pkg::REQ_W-1:0]          i_req_type,
    input  logic [prt_pkg::ADDR_W-1:0]         i_phys_addr,
    output logic                               o_valid,
    output logic [prt_pkg::STATUS_W-1:0]       o_status,
    output logic [prt_pkg::COUNT_W-1:0]        o_ref_count,
    output logic [prt_pkg::LIVE_OUT_W-1:0]     o_live_groups
);

    // Sizes
    localparam int TOTAL = ENTRIES_PER_GROUP * NUM_GROUPS;
    localparam int PW    = $clog2(TOTAL);                         // page index
    localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int NZW   = $clog2(ENTRIES_PER_GROUP + 1);         // nonzero count
    localparam int GWD   = NZW + 1;                               // {valid, nz}
    localparam int LW    = $clog2(NUM_GROUPS + 1);                // live total

    // Group index = page / ENTRIES_PER_GROUP via exact reciprocal multiply:
    // with l = ceil(log2 d) and m = ceil(2^(PW+l) / d), (n*m) >> (PW+l) is
    // floor(n/d) for every n below 2^PW.
    localparam int EL = $clog2(ENTRIES_PER_GROUP);
    localparam int SH = PW + EL;
    localparam int MW = PW + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(ENTRIES_PER_GROUP) - 64'd1) / 64'(ENTRIES_PER_GROUP);

    // Control
    prt_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_clr_addr;
    logic [LW-1:0]   r_live, n_live;
    logic            r_valid;

    // Request payload
    logic [prt_pkg::REQ_W-1:0] r_req;
    logic [PW-1:0]             r_page;
    logic                      r_oor;
    logic [GW-1:0]             r_grp;

    // Result payload
    prt_pkg::t_status          r_status, n_status;
    logic [prt_pkg::COUNT_W-1:0] r_count, n_count;

    // Address decode at the input
    logic [prt_pkg::ADDR_W-1:0] w_page_full;
    logic                       w_accept;
    logic                       w_clr_last;
    logic [PW+MW-1:0]           w_prod;

    // Memory ports
    logic                        w_cnt_we, w_cnt_re;
    logic [PW-1:0]               w_cnt_waddr;
    logic [prt_pkg::COUNT_W-1:0] w_cnt_wdata, w_cnt_rdata;
    logic                        w_grp_we, w_grp_re;
    logic [GW-1:0]               w_grp_waddr;
    logic [GWD-1:0]              w_grp_wdata, w_grp_rdata;

    // Update results from the EXEC step
    logic                        x_cnt_we, x_grp_we;
    logic [prt_pkg::COUNT_W-1:0] x_cnt_wdata;
    logic [GWD-1:0]              x_grp_wdata;
    logic                        g_valid;
    logic [NZW-1:0]              g_nz, g_nz_dec;

    assign w_page_full = i_phys_addr >> PAGE_BITS;
    assign w_accept    = start && !busy;
    assign w_clr_last  = (r_clr_addr == PW'(TOTAL - 1));
    assign w_prod      = (PW+MW)'(r_page) * (PW+MW)'(RECIP[MW-1:0]);

    assign g_valid = w_grp_rdata[GWD-1];
    assign g_nz    = w_grp_rdata[NZW-1:0];

    // ---------------------------------------------------------------
    // Memories: one count per page, one {valid, nonzero count} per group
    // ---------------------------------------------------------------
    prt_ram #(
        .WIDTH (prt_pkg::COUNT_W),
        .DEPTH (TOTAL)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_cnt_re),
        .i_raddr (r_page),
        .o_rdata (w_cnt_rdata)
    );

    prt_ram #(
        .WIDTH (GWD),
        .DEPTH (NUM_GROUPS)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (w_grp_we),
        .i_waddr (w_grp_waddr),
        .i_wdata (w_grp_wdata),
        .i_re    (w_grp_re),
        .i_raddr (r_grp),
        .o_rdata (w_grp_rdata)
    );

    // ---------------------------------------------------------------
    // Read-modify-write of one count and one group word
    // ---------------------------------------------------------------
    always_comb begin
        x_cnt_we    = 1'b0;
        x_grp_we    = 1'b0;
        x_cnt_wdata = w_cnt_rdata;
        x_grp_wdata = w_grp_rdata;
        n_live      = r_live;
        n_status    = prt_pkg::ST_OK;
        n_count     = w_cnt_rdata;
        // nonzero count after a decrement that may zero this page
        g_nz_dec    = g_nz;
        if ((w_cnt_rdata == 16'd1) && (g_nz != '0)) begin
            g_nz_dec = g_nz - NZW'(1);
        end

        if (r_req == prt_pkg::REQ_REGISTER) begin
            if (w_cnt_rdata == prt_pkg::COUNT_MAX) begin
                n_status = prt_pkg::ST_OVERFLOW;
            end else begin
                x_cnt_we    = 1'b1;
                x_cnt_wdata = w_cnt_rdata + 16'd1;
                n_count     = x_cnt_wdata;
                x_grp_we    = 1'b1;
                // a group going live restarts its nonzero count
                x_grp_wdata = {1'b1, (g_valid ? g_nz : NZW'(0))
                                     + NZW'(w_cnt_rdata == '0)};
                if (!g_valid) begin
                    n_live = LW'(r_live + LW'(1));
                end
            end
        end else if (!g_valid) begin
            n_status = prt_pkg::ST_ABSENT;
            n_count  = '0;
        end else if (r_req == prt_pkg::REQ_DEREGISTER) begin
            if (w_cnt_rdata == '0) begin
                n_status = prt_pkg::ST_UNDERFLOW;
            end else begin
                x_cnt_we    = 1'b1;
                x_cnt_wdata = w_cnt_rdata - 16'd1;
                n_count     = x_cnt_wdata;
                x_grp_we    = 1'b1;
                x_grp_wdata = {(g_nz_dec != '0), g_nz_dec};
                if ((g_nz_dec == '0) && (r_live != '0)) begin
                    n_live = LW'(r_live - LW'(1));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            prt_pkg::S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = prt_pkg::S_IDLE;
                end
            end
            prt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = prt_pkg::S_MUL;
                end
            end
            prt_pkg::S_MUL: begin
                n_state = r_oor ? prt_pkg::S_IDLE : prt_pkg::S_READ;
            end
            prt_pkg::S_READ: begin
                n_state = prt_pkg::S_EXEC;
            end
            prt_pkg::S_EXEC: begin
                n_state = prt_pkg::S_IDLE;
            end
            default: begin
                n_state = prt_pkg::S_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs and memory port control
    // ---------------------------------------------------------------
    always_comb begin
        busy        = 1'b1;
        w_cnt_re    = 1'b0;
        w_grp_re    = 1'b0;
        w_cnt_we    = 1'b0;
        w_grp_we    = 1'b0;
        w_cnt_waddr = r_page;
        w_cnt_wdata = x_cnt_wdata;
        w_grp_waddr = r_grp;
        w_grp_wdata = x_grp_wdata;
        case (r_state)
            prt_pkg::S_CLEAR: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_clr_addr;
                w_cnt_wdata = '0;
                // group store is shallower; only its own range is swept
                w_grp_we    = (r_clr_addr < PW'(NUM_GROUPS));
                w_grp_waddr = GW'(r_clr_addr);
                w_grp_wdata = '0;
            end
            prt_pkg::S_IDLE: begin
                busy = 1'b0;
            end
            prt_pkg::S_MUL: begin
                busy = 1'b1;
            end
            prt_pkg::S_READ: begin
                w_cnt_re = 1'b1;
                w_grp_re = 1'b1;
            end
            prt_pkg::S_EXEC: begin
                w_cnt_we = x_cnt_we;
                w_grp_we = x_grp_we;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prt_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_live     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (r_state == prt_pkg::S_CLEAR) begin
                r_clr_addr <= PW'(r_clr_addr + PW'(1));
            end
            if ((r_state == prt_pkg::S_MUL) && r_oor) begin
                r_valid <= 1'b1;
            end
            if (r_state == prt_pkg::S_EXEC) begin
                r_valid <= 1'b1;
                r_live  <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_page <= PW'(w_page_full);
            r_oor  <= (w_page_full >= prt_pkg::ADDR_W'(TOTAL));
        end
        if (r_state == prt_pkg::S_MUL) begin
            r_grp    <= GW'(w_prod >> SH);
            r_status <= prt_pkg::ST_RANGE;
            r_count  <= '0;
        end
        if (r_state == prt_pkg::S_EXEC) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_ref_count   = r_count;
    assign o_live_groups = prt_pkg::LIVE_OUT_W'(r_live);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PRT_ASSERT_IMP(a_live_bound, i_clk, i_rst_n, 1'b1,
        r_live <= LW'(NUM_GROUPS), "live group total exceeds group count")
    `PRT_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, start && !busy,
        r_state == prt_pkg::S_MUL, "accepted word did not enter the multiply step")
    `PRT_ASSERT_IMP(a_strobe_source, i_clk, i_rst_n, o_valid,
        ($past(r_state) == prt_pkg::S_EXEC) || ($past(r_state) == prt_pkg::S_MUL),
        "result strobe without a finishing step")
    `PRT_ASSERT_IMP(a_overflow_count, i_clk, i_rst_n,
        o_valid && (o_status == prt_pkg::ST_OVERFLOW),
        o_ref_count == prt_pkg::COUNT_MAX, "overflow reported below the count limit")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for page_refcount_table: predicted results vs. the block's result words.
module testbench;
    import prt_pkg::*;

    // Geometry of the table under test; it must match the parameters passed to dut.
    localparam int PAGE_BITS         = 12;
    localparam int ENTRIES_PER_GROUP = 1024;
    localparam int NUM_GROUPS        = 64;
    localparam int TOTAL_PAGES       = ENTRIES_PER_GROUP * NUM_GROUPS;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    // The post-reset memory sweep writes all TOTAL_PAGES entries with nothing
    // accepted, so the watchdog limit sits well above the sweep.
    localparam int STALL_LIMIT  = 3 * TOTAL_PAGES;
    localparam int DRAIN_CYCLES = 8;

    localparam int ITEMS_PER_PHASE = 450;
    localparam int HOT_PAGES       = 12;

    // Request code 3 is unused by the block and is decoded as a query.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        t_status                 status;
        logic [COUNT_W-1:0]      ref_count;
        logic [LIVE_OUT_W-1:0]   live_groups;
    } t_reply;

    // Shadow copy of the count table plus the queue of result words still owed.
    class refcount_tracker;
        bit [COUNT_W-1:0] counts [TOTAL_PAGES];
        bit               group_live [NUM_GROUPS];
        int unsigned      nonzero [NUM_GROUPS];
        int unsigned      live_total;
        t_reply           pending [$];
        int unsigned      failures;
        int unsigned      requests;
        int unsigned      releases;
        int unsigned      status_tally [5];

        // Apply one accepted request word to the shadow table and queue its result.
        function void note_request(input logic [REQ_W-1:0] req,
                                   input logic [ADDR_W-1:0] addr);
            logic [ADDR_W-PAGE_BITS-1:0] page;
            int unsigned                 grp;
            logic [COUNT_W-1:0]          cnt;
            t_status                     st;
            page = addr >> PAGE_BITS;
            st   = ST_OK;
            cnt  = '0;
            requests++;
            if (page >= TOTAL_PAGES) begin
                st = ST_RANGE;
            end else begin
                grp = page / ENTRIES_PER_GROUP;
                cnt = counts[page];
                if (req == REQ_REGISTER) begin
                    if (cnt == COUNT_MAX) begin
                        st = ST_OVERFLOW;
                    end else begin
                        if (!group_live[grp]) begin
                            group_live[grp] = 1'b1;
                            nonzero[grp]    = 0;
                            live_total++;
                        end
                        if (cnt == 0)
                            nonzero[grp]++;
                        cnt++;
                        counts[page] = cnt;
                    end
                end else if (!group_live[grp]) begin
                    st  = ST_ABSENT;
                    cnt = '0;
                end else if (req == REQ_DEREGISTER) begin
                    if (cnt == 0) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        cnt--;
                        counts[page] = cnt;
                        if (cnt == 0 && nonzero[grp] > 0)
                            nonzero[grp]--;
                        if (nonzero[grp] == 0) begin
                            group_live[grp] = 1'b0;
                            releases++;
                            if (live_total > 0)
                                live_total--;
                        end
                    end
                end
                // query and the spare code leave the table alone
            end
            status_tally[st]++;
            pending.push_back('{st, cnt, LIVE_OUT_W'(live_total)});
        endfunction

        // Compare one result word with the oldest owed result.
        function void check_reply(input logic [STATUS_W-1:0]   status,
                                  input logic [COUNT_W-1:0]    ref_count,
                                  input logic [LIVE_OUT_W-1:0] live_groups);
            t_reply want;
            if (pending.size() == 0) begin
                $error("unrequested result word: status %0d ref_count %0d live_groups %0d",
                       status, ref_count, live_groups);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (ref_count !== want.ref_count) begin
                $error("ref_count: expected %0d, got %0d", want.ref_count, ref_count);
                failures++;
            end
            if (live_groups !== want.live_groups) begin
                $error("live_groups: expected %0d, got %0d", want.live_groups, live_groups);
                failures++;
            end
        endfunction
    endclass

    // All block inputs start at known values.
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic [REQ_W-1:0]        i_req_type  = REQ_QUERY;
    logic [ADDR_W-1:0]       i_phys_addr = '0;
    logic                    busy;
    logic                    o_valid;
    logic [STATUS_W-1:0]     o_status;
    logic [COUNT_W-1:0]      o_ref_count;
    logic [LIVE_OUT_W-1:0]   o_live_groups;

    refcount_tracker tracker = new();

    // Chance, in percent, that the sender holds start low before a request, tried again after every idle clock.
    int unsigned gap_pct = 0;
    int unsigned quiet_cycles = 0;
    logic [15:0] hot_pages [HOT_PAGES];

    page_refcount_table #(
        .PAGE_BITS         (PAGE_BITS),
        .ENTRIES_PER_GROUP (ENTRIES_PER_GROUP),
        .NUM_GROUPS        (NUM_GROUPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_phys_addr   (i_phys_addr),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_ref_count   (o_ref_count),
        .o_live_groups (o_live_groups)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Monitor: reads the values the block saw at this edge (all updates are
    // nonblocking, so nothing here races the design). The result word is
    // checked before the new request is noted; a word shown in the accepting
    // cycle always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_reply(o_status, o_ref_count, o_live_groups);
            if (start && !busy)
                tracker.note_request(i_req_type, i_phys_addr);
        end
    end

    // Watchdog: counts edges with no word moving in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results owed",
                     STALL_LIMIT, tracker.pending.size());
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request word and hold it until the edge that accepts it.
    // start is left high on return; the next call or the end of stimulus
    // decides its next value, so it gets one assignment per edge.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_phys_addr <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    // Registers and deregisters balance so counts hover near zero and groups
    // keep going live and being released; queries and the spare code fill in.
    function automatic logic [REQ_W-1:0] pick_request();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 42)      return REQ_REGISTER;
        else if (sel < 82) return REQ_DEREGISTER;
        else if (sel < 95) return REQ_QUERY;
        else               return REQ_SPARE;
    endfunction

    // Mostly a small set of hot pages (so sequences build up real counts),
    // then random in-range pages, out-of-range addresses and fixed corners.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int unsigned       sel;
        a   = ADDR_W'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            a = {20'h0, hot_pages[$urandom_range(0, HOT_PAGES - 1)], a[PAGE_BITS-1:0]};
        end else if (sel < 80) begin
            a[ADDR_W-1:28] = '0;
        end else if (sel < 92) begin
            // force the page number to the table size or beyond
            if (a[ADDR_W-1:28] == 0)
                a[28 + $urandom_range(0, ADDR_W - 29)] = 1'b1;
        end else begin
            case ($urandom_range(0, 3))
                0:       a = '0;
                1:       a = 48'h0000_0FFF_FFFF;
                2:       a = 48'h0000_1000_0000;
                default: a = '1;
            endcase
        end
        return a;
    endfunction

    initial begin
        int unsigned grp;
        int unsigned off;

        // hot pages: first and last entry of four spread-out groups, plus four
        // random pages anywhere in the table
        for (int k = 0; k < HOT_PAGES; k++) begin
            if (k < 8) begin
                grp = (k / 2) * 20;
                off = (k % 2) ? ENTRIES_PER_GROUP - 1 : 0;
            end else begin
                grp = $urandom_range(0, NUM_GROUPS - 1);
                off = $urandom_range(0, ENTRIES_PER_GROUP - 1);
            end
            hot_pages[k] = 16'(grp * ENTRIES_PER_GROUP + off);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back. The first request waits out the sweep.
        // Fresh table: every group absent, spare code acting as a query.
        send_request(REQ_QUERY,      48'h0);
        send_request(REQ_DEREGISTER, 48'h0);
        send_request(REQ_SPARE,      48'h0);
        // First page past the table, all-ones address, top address bit alone.
        send_request(REQ_REGISTER,   48'h0000_1000_0000);
        send_request(REQ_DEREGISTER, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_QUERY,      48'h8000_0000_0000);
        // Group 0 goes live, page 0 counts to 2, neighbor page underflows.
        send_request(REQ_REGISTER,   48'h0);
        send_request(REQ_REGISTER,   48'h0000_0000_0FFF);
        send_request(REQ_SPARE,      48'h0000_0000_0123);
        send_request(REQ_DEREGISTER, 48'h0000_0000_1000);
        // Count back to zero releases group 0; it reads as absent again.
        send_request(REQ_DEREGISTER, 48'h0000_0000_0800);
        send_request(REQ_DEREGISTER, 48'h0);
        send_request(REQ_QUERY,      48'h0);
        // Pages on either side of a group boundary, then the last page.
        send_request(REQ_REGISTER,   48'h0000_003F_F000);
        send_request(REQ_REGISTER,   48'h0000_0040_0000);
        send_request(REQ_REGISTER,   48'h0000_0FFF_FFFF);
        send_request(REQ_DEREGISTER, 48'h0000_003F_F000);
        send_request(REQ_DEREGISTER, 48'h0000_0040_0FFF);
        // Last page: count up and down inside the top group.
        send_request(REQ_REGISTER,   48'h0000_0FFF_F000);
        send_request(REQ_QUERY,      48'h0000_0FFF_F000);
        send_request(REQ_DEREGISTER, 48'h0000_0FFF_F000);
        send_request(REQ_REGISTER,   48'h0000_0FFF_F000);
        send_request(REQ_REGISTER,   48'h0000_0FFF_F7FF);

        // Random part: sender idles 29%, then 71%, then never.
        gap_pct = 29;
        repeat (ITEMS_PER_PHASE) send_request(pick_request(), pick_address());
        gap_pct = 71;
        repeat (ITEMS_PER_PHASE) send_request(pick_request(), pick_address());
        gap_pct = 0;
        repeat (ITEMS_PER_PHASE) send_request(pick_request(), pick_address());
        start <= 1'b0;

        // Drain: every owed result word, then further idle edges to catch strays.
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d ok, %0d out of range, %0d absent, %0d underflow, %0d overflow",
                 tracker.requests, tracker.status_tally[ST_OK], tracker.status_tally[ST_RANGE],
                 tracker.status_tally[ST_ABSENT], tracker.status_tally[ST_UNDERFLOW],
                 tracker.status_tally[ST_OVERFLOW]);
        $display("%0d group releases, %0d mismatches",
                 tracker.releases, tracker.failures);
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/prt_pkg.sv
src/prt_ram.sv
src/page_refcount_table.sv
tb/sv/testbench.sv
